FILE: sv/shamh_pkg.sv
`timescale 1ns / 1ps

package shamh_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;
    typedef logic [63:0] length_t;

    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned HASH_WORDS      = 8;
    localparam int unsigned ROUNDS          = 64;

    // Padding marker byte
    localparam byte_t PAD_MARK = 8'h80;

    // Block fill position at which the length field starts
    localparam logic [5:0] LEN_START = 6'd56;

    localparam word_t INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Big sigma 0: rotr 2, 13, 22
    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Big sigma 1: rotr 6, 11, 25
    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Small sigma 0: rotr 7, rotr 18, shr 3
    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Small sigma 1: rotr 17, rotr 19, shr 10
    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

FILE: sv/shamh_chan_if.sv
`timescale 1ns / 1ps

// Message byte channel
interface shamh_in_if;
    logic                 valid;
    logic                 ready;
    shamh_pkg::byte_t     data_byte;
    logic                 byte_present;
    logic                 end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

// Digest word channel
interface shamh_out_if;
    logic                 valid;
    logic                 ready;
    shamh_pkg::word_t     digest_word;
    logic                 digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

FILE: sv/sha256_message_hasher.sv
`timescale 1ns / 1ps

// SHA-256 hasher fed one message byte per request.
// Input channel in_chan: data_byte, byte_present, end_of_message. A request with
// byte_present low adds no byte; with end_of_message high it closes the message,
// so an empty message is a single request with byte_present low and
// end_of_message high.
// Output channel out_chan: eight digest words, word 0 first, digest_last on the
// eighth. After it the hasher starts a new message from the initial hash.
// Sequence: a byte that does not complete a block is written in while idle. A byte that
// completes a 64-byte block starts 64 rounds through the single round unit, one
// per cycle, then a fold of the result into the hash. A closing request pushes
// the padding bytes one at a time (0x80, zeros, 8 length bytes, 9 to 72 bytes),
// compresses each block it fills, then sends the eight digest words, one per
// cycle when the receiver takes them. Sustained throughput is set by the shared
// round unit: no request is taken while a block is compressed.
// in_chan.ready is high only while idle; the block takes one request at a time.
// While the receiver stalls, the current digest word holds and no request is
// taken. Reset loads the initial hash and clears length and byte counts.
module sha256_message_hasher (
    input  logic               clk,
    input  logic               rst_n,
    shamh_in_if.sink           in_chan,
    shamh_out_if.source        out_chan
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PAD_MARK = 3'd1;
    localparam logic [2:0] S_PAD_ZERO = 3'd2;
    localparam logic [2:0] S_PAD_LEN  = 3'd3;
    localparam logic [2:0] S_ROUND    = 3'd4;
    localparam logic [2:0] S_FOLD     = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [2:0]              ret_reg, ret_next;
    logic [5:0]              count_reg;
    logic [5:0]              round_reg;
    logic [2:0]              out_cnt_reg;
    shamh_pkg::length_t      bit_length_reg;
    shamh_pkg::word_t        hash_reg [shamh_pkg::HASH_WORDS];
    shamh_pkg::word_t        wv_reg   [shamh_pkg::HASH_WORDS];
    shamh_pkg::word_t        win_reg  [shamh_pkg::WORDS_PER_BLOCK];

    logic                    in_fire;
    logic                    out_fire;
    logic                    wr_en;
    shamh_pkg::byte_t        wr_byte;
    logic [5:0]              count_inc;
    logic                    block_full;
    logic [2:0]              follow_state;

    shamh_pkg::word_t        w_cur, w_new, t1, t2;

    assign in_chan.ready        = (state_reg == S_IDLE);
    assign in_fire              = in_chan.valid && in_chan.ready;
    assign out_chan.valid       = (state_reg == S_OUT);
    assign out_chan.digest_word = hash_reg[0];
    assign out_chan.digest_last = (out_cnt_reg == 3'd7);
    assign out_fire             = out_chan.valid && out_chan.ready;

    assign count_inc  = count_reg + 6'd1;
    assign block_full = wr_en && (count_reg == 6'd63);

    // Select the byte to push and the state that follows it
    always_comb
    begin
        wr_en        = 1'b0;
        wr_byte      = in_chan.data_byte;
        follow_state = S_IDLE;
        unique case (state_reg) inside
            S_IDLE:
            begin
                wr_en        = in_fire && in_chan.byte_present;
                follow_state = (in_fire && in_chan.end_of_message) ? S_PAD_MARK : S_IDLE;
            end
            S_PAD_MARK:
            begin
                wr_en        = 1'b1;
                wr_byte      = shamh_pkg::PAD_MARK;
                follow_state = (count_inc == shamh_pkg::LEN_START) ? S_PAD_LEN : S_PAD_ZERO;
            end
            S_PAD_ZERO:
            begin
                wr_en        = 1'b1;
                wr_byte      = 8'h00;
                follow_state = (count_inc == shamh_pkg::LEN_START) ? S_PAD_LEN : S_PAD_ZERO;
            end
            S_PAD_LEN:
            begin
                wr_en        = 1'b1;
                wr_byte      = bit_length_reg[{~count_reg[2:0], 3'b000} +: 8];
                follow_state = (count_reg == 6'd63) ? S_OUT : S_PAD_LEN;
            end
            S_ROUND, S_FOLD, S_OUT:
            begin
                follow_state = S_IDLE;
            end
            default:
            begin
                follow_state = S_IDLE;
            end
        endcase
    end

    // Sequence bytes, rounds, fold and digest output
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg) inside
            S_IDLE, S_PAD_MARK, S_PAD_ZERO, S_PAD_LEN:
            begin
                if (block_full)
                begin
                    state_next = S_ROUND;
                    ret_next   = follow_state;
                end
                else
                begin
                    state_next = follow_state;
                end
            end
            S_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (out_fire && (out_cnt_reg == 3'd7))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Round unit: schedule word and compression step
    assign w_cur = win_reg[0];
    assign w_new = shamh_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                 + shamh_pkg::small_sigma0(win_reg[1]) + win_reg[0];
    assign t1 = wv_reg[7] + shamh_pkg::big_sigma1(wv_reg[4])
              + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
              + shamh_pkg::ROUND_K[round_reg] + w_cur;
    assign t2 = shamh_pkg::big_sigma0(wv_reg[0])
              + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                 ^ (wv_reg[1] & wv_reg[2]));

    // Hold control state and hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            count_reg      <= 6'd0;
            round_reg      <= 6'd0;
            out_cnt_reg    <= 3'd0;
            bit_length_reg <= 64'd0;
            for (int k = 0; k < shamh_pkg::HASH_WORDS; k++)
                hash_reg[k] <= shamh_pkg::INIT_HASH[k];
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (wr_en)
                count_reg <= count_inc;
            if (in_fire && in_chan.byte_present)
                bit_length_reg <= bit_length_reg + 64'd8;
            if (state_reg == S_ROUND)
                round_reg <= round_reg + 6'd1;
            // Fold the working variables into the hash
            if (state_reg == S_FOLD)
            begin
                for (int k = 0; k < shamh_pkg::HASH_WORDS; k++)
                    hash_reg[k] <= hash_reg[k] + wv_reg[k];
            end
            // Shift the digest out and rotate the initial hash back in
            if (out_fire)
            begin
                for (int k = 0; k < shamh_pkg::HASH_WORDS - 1; k++)
                    hash_reg[k] <= hash_reg[k + 1];
                hash_reg[shamh_pkg::HASH_WORDS - 1] <= shamh_pkg::INIT_HASH[out_cnt_reg];
                out_cnt_reg <= out_cnt_reg + 3'd1;
                if (out_cnt_reg == 3'd7)
                    bit_length_reg <= 64'd0;
            end
        end
    end

    // Pack bytes into the window, advance the schedule and working variables
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (count_reg[1:0] == 2'b00)
                win_reg[count_reg[5:2]] <= {wr_byte, 24'h000000};
            else
                win_reg[count_reg[5:2]][{~count_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
        if (block_full)
        begin
            for (int k = 0; k < shamh_pkg::HASH_WORDS; k++)
                wv_reg[k] <= hash_reg[k];
        end
        if (state_reg == S_ROUND)
        begin
            for (int k = 0; k < shamh_pkg::WORDS_PER_BLOCK - 1; k++)
                win_reg[k] <= win_reg[k + 1];
            win_reg[shamh_pkg::WORDS_PER_BLOCK - 1] <= w_new;
            for (int k = 1; k < shamh_pkg::HASH_WORDS; k++)
                wv_reg[k] <= wv_reg[k - 1];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[0] <= t1 + t2;
        end
    end

    // Never take a request while a digest is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_chan.ready |-> !out_chan.valid)
        else $error("request taken while digest pending");

    // Last round leads to the fold
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && round_reg == 6'd63) |=> (state_reg == S_FOLD))
        else $error("round sequence broken");

    // Digest starts at a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid |-> (count_reg == 6'd0 && round_reg == 6'd0))
        else $error("digest before final block done");

    // Last digest word returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_chan.digest_last) |=> in_chan.ready)
        else $error("no return to idle after digest");

endmodule
